// ===== rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg - shared definitions for the sliding window median filter
// Default sizes, the window size register and the control broadcast that
// the top level hands to every sorting cell.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;

  // window size register
  localparam int                 CFG_BITS    = 7;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;

  // broadcast to the cell row for one item
  typedef struct packed {
    logic load;   // an item is taken this cycle
    logic clear;  // window is emptied before the sample goes in
    logic full;   // window full: the oldest sample leaves
  } swm_ctrl_t;

endpackage

// ===== rtl/swm_in_if.sv =====
// ----------------------------------------------------------------------------
// swm_in_if - sample channel
// Valid/ready channel carrying one sample and the restart flag per item.
// ----------------------------------------------------------------------------
interface swm_in_if #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

// ===== rtl/swm_out_if.sv =====
// ----------------------------------------------------------------------------
// swm_out_if - result channel
// Valid/ready channel carrying the doubled window median per item.
// ----------------------------------------------------------------------------
interface swm_out_if #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] median_doubled;

  modport source (output valid, output median_doubled, input ready);
  modport sink   (input valid, input median_doubled, output ready);
endinterface

// ===== rtl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell - one slot of the sorted window
// Holds one sample and its age; on each item it keeps its entry, takes a
// neighbor's entry or takes the new sample, so the row stays sorted.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int SB = swm_pkg::SAMPLE_BITS_DEF,
  parameter int AW = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swm_pkg::swm_ctrl_t  ctrl_i,
  input  logic [SB-1:0]       sample_i,
  input  logic [AW-1:0]       oldest_age_i,
  input  logic [SB-1:0]       left_val_i,
  input  logic [AW-1:0]       left_age_i,
  input  logic                left_gt_i,
  input  logic                left_vld_i,
  input  logic [SB-1:0]       right_val_i,
  input  logic [AW-1:0]       right_age_i,
  input  logic                right_gt_i,
  input  logic                rmb_i,
  output logic [SB-1:0]       val_o,
  output logic [AW-1:0]       age_o,
  output logic                gt_o,
  output logic                vld_o,
  output logic                rm_o,
  output logic                rmb_o
);
  import swm_pkg::*;

  typedef enum logic [1:0] {
    SRC_SELF  = 2'd0,
    SRC_LEFT  = 2'd1,
    SRC_RIGHT = 2'd2,
    SRC_NEW   = 2'd3
  } src_e;

  logic [SB-1:0] val_q, val_d;
  logic [AW-1:0] age_q, age_d;
  logic          vld_q, vld_d;
  logic          vld_eff, gt, rm;
  src_e          src;

  assign vld_eff = vld_q & ~ctrl_i.clear;
  // empty slots act as larger than any sample
  assign gt      = ~vld_eff | ($signed(val_q) > $signed(sample_i));
  assign rm      = ctrl_i.full & vld_eff & (age_q == oldest_age_i);

  always_comb begin
    if (rmb_i) begin
      // right of the leaving entry: close the gap
      src   = right_gt_i ? (gt ? SRC_SELF : SRC_NEW) : SRC_RIGHT;
      vld_d = vld_eff;
    end else if (rm) begin
      src   = left_gt_i ? SRC_LEFT : (right_gt_i ? SRC_NEW : SRC_RIGHT);
      vld_d = vld_eff;
    end else begin
      // left of the leaving entry, or filling: open a gap
      src   = gt ? (left_gt_i ? SRC_LEFT : SRC_NEW) : SRC_SELF;
      vld_d = vld_eff | left_vld_i;
    end
  end

  always_comb begin
    case (src)
      SRC_SELF: begin
        val_d = val_q;
        age_d = age_q + AW'(1);
      end
      SRC_LEFT: begin
        val_d = left_val_i;
        age_d = left_age_i + AW'(1);
      end
      SRC_RIGHT: begin
        val_d = right_val_i;
        age_d = right_age_i + AW'(1);
      end
      default: begin
        val_d = sample_i;
        age_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.load) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o = val_q;
  assign age_o = age_q;
  assign gt_o  = gt;
  assign vld_o = vld_eff;
  assign rm_o  = rm;
  assign rmb_o = rmb_i | rm;

endmodule

// ===== rtl/swm_median.sv =====
// ----------------------------------------------------------------------------
// swm_median - middle entry pick and sum
// Picks the one or two middle entries of the sorted row for the current
// window and adds them, giving twice the median.
// ----------------------------------------------------------------------------
module swm_median #(
  parameter int SB = swm_pkg::SAMPLE_BITS_DEF,
  parameter int MW = swm_pkg::MAX_WINDOW_DEF,
  parameter int KW = 7
) (
  input  logic [SB-1:0] vals_i [MW],
  input  logic [KW-1:0] k_i,
  output logic [SB:0]   median_o
);
  import swm_pkg::*;

  logic [KW-1:0] idx_hi, idx_lo;
  logic [SB-1:0] hi, lo;

  assign idx_hi = k_i >> 1;
  // odd window: both picks are the middle entry
  assign idx_lo = k_i[0] ? idx_hi : idx_hi - KW'(1);

  always_comb begin
    hi = '0;
    lo = '0;
    for (int i = 0; i < MW; i++) begin
      hi = hi | (vals_i[i] & {SB{KW'(i) == idx_hi}});
      lo = lo | (vals_i[i] & {SB{KW'(i) == idx_lo}});
    end
  end

  assign median_o = {hi[SB-1], hi} + {lo[SB-1], lo};

endmodule

// ===== rtl/sliding_window_median.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median - running median filter
// Keeps the last window_size samples in a sorted row of cells and returns
// twice the window median (one fractional bit) for each sample once the
// window is full.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  in_i      in   valid/ready        sample, restart
//  out_o     out  valid/ready        median_doubled
//  cfg       in   cfg_we_i (no ack)  cfg_wdata_i = window_size
//
//  an item that fills the window without a result only updates the cell row
//  an item with a result goes through cell row update, then median pick and
//  add into the output register
//  reset and a window_size write empty the window; no clearing pass needed
//  a stalled result holds in the output register; in_i.ready drops while
//  a result is pending or the output register cannot take it
//
module sliding_window_median #(
  parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swm_pkg::CFG_BITS-1:0]  cfg_wdata_i,
  swm_in_if.sink                        in_i,
  swm_out_if.source                     out_o
);
  import swm_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);      // age of a sample in the window
  localparam int KW = $clog2(MAX_WINDOW + 1);  // window length and fill count

  // configuration and fill state
  logic [CFG_BITS-1:0] wsize_q;
  logic [KW-1:0]       k_w, km1_w, n_w, cnt_q, cnt_d;
  logic                accept, clear, full, result_w;
  swm_ctrl_t           ctrl;

  // cell row
  logic [SAMPLE_BITS-1:0] val_w [MAX_WINDOW];
  logic [AW-1:0]          age_w [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  gt_w, vld_w, rm_w;
  logic [MAX_WINDOW:0]    rmb_w;

  // result path
  logic                 pend_q;
  logic                 ov_q;
  logic [SAMPLE_BITS:0] od_q;
  logic [SAMPLE_BITS:0] median_w;

  // active window: zero means one, saturate at the row length
  always_comb begin
    if (wsize_q == '0) begin
      k_w = KW'(1);
    end else if (int'(wsize_q) > MAX_WINDOW) begin
      k_w = KW'(MAX_WINDOW);
    end else begin
      k_w = KW'(wsize_q);
    end
  end
  assign km1_w = k_w - KW'(1);

  assign accept   = in_i.valid & in_i.ready;
  // an empty fill count means stale cells, so drop them as well
  assign clear    = in_i.restart | (cnt_q == '0);
  assign n_w      = clear ? '0 : cnt_q;
  assign full     = (n_w == k_w);
  assign result_w = full | ((n_w + KW'(1)) == k_w);
  assign cnt_d    = full ? k_w : n_w + KW'(1);

  assign ctrl.load  = accept;
  assign ctrl.clear = clear;
  assign ctrl.full  = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= WINDOW_RESET;
      cnt_q   <= '0;
    end else if (cfg_we_i) begin
      wsize_q <= cfg_wdata_i;
      cnt_q   <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  // sorted row: cell 0 holds the smallest sample; the leaving entry is
  // found by age, and everything right of it knows through the rmb chain
  assign rmb_w[0] = 1'b0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] left_val, right_val;
    logic [AW-1:0]          left_age, right_age;
    logic                   left_gt, left_vld, right_gt;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_age = '0;
      assign left_gt  = 1'b0;
      assign left_vld = 1'b1;
    end else begin : g_mid_l
      assign left_val = val_w[i-1];
      assign left_age = age_w[i-1];
      assign left_gt  = gt_w[i-1];
      assign left_vld = vld_w[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign right_val = '0;
      assign right_age = '0;
      assign right_gt  = 1'b1;
    end else begin : g_mid_r
      assign right_val = val_w[i+1];
      assign right_age = age_w[i+1];
      assign right_gt  = gt_w[i+1];
    end

    swm_cell #(
      .SB (SAMPLE_BITS),
      .AW (AW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .sample_i     (in_i.sample),
      .oldest_age_i (km1_w[AW-1:0]),
      .left_val_i   (left_val),
      .left_age_i   (left_age),
      .left_gt_i    (left_gt),
      .left_vld_i   (left_vld),
      .right_val_i  (right_val),
      .right_age_i  (right_age),
      .right_gt_i   (right_gt),
      .rmb_i        (rmb_w[i]),
      .val_o        (val_w[i]),
      .age_o        (age_w[i]),
      .gt_o         (gt_w[i]),
      .vld_o        (vld_w[i]),
      .rm_o         (rm_w[i]),
      .rmb_o        (rmb_w[i+1])
    );
  end

  swm_median #(
    .SB (SAMPLE_BITS),
    .MW (MAX_WINDOW),
    .KW (KW)
  ) u_median (
    .vals_i   (val_w),
    .k_i      (k_w),
    .median_o (median_w)
  );

  // pend_q marks a result whose cells were updated last cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      pend_q <= accept & result_w;
      if (pend_q) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      od_q <= median_w;
    end
  end

  // take an item only if the output register is free by the time its
  // result comes out of the cell row
  assign in_i.ready           = ~pend_q & (~ov_q | out_o.ready);
  assign out_o.valid          = ov_q;
  assign out_o.median_doubled = od_q;

  // a pending result always lands in the output register
  a_pend_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> ov_q)
    else $error("pending median did not reach the output register");

  // fill count never passes the window
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= k_w)
    else $error("fill count beyond window size");

  // a full window drops exactly one entry
  a_one_leaves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full) |-> $onehot(rm_w))
    else $error("full window update without a single leaving entry");

  // occupied cells match the fill count
  a_occupancy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_i.restart && cnt_q != '0) |-> ($countones(vld_w) == int'(cnt_q)))
    else $error("cell occupancy differs from fill count");

endmodule
